>>> hdl/macro_op_fusion_table_macros.svh
// Assertion macros used by the checker file.
`ifndef MACRO_OP_FUSION_TABLE_MACROS_SVH
`define MACRO_OP_FUSION_TABLE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define MOFT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MOFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/moft_pkg.sv
//------------------------------------------------------------------------------
// moft_pkg
// Shared types, codes and the pair classifier for the fusion table.
//------------------------------------------------------------------------------
`default_nettype none
package moft_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
    localparam int USED_W      = 10;

    typedef enum logic [0:0] {
        ACT_FUSE   = 1'b0,
        ACT_LOOKUP = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_FUSED    = 2'd0,
        ST_NO_FUSE  = 2'd1,
        ST_HIT      = 2'd2,
        ST_MISS     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        KIND_CMP_JCC  = 3'd0,
        KIND_TEST_JCC = 3'd1,
        KIND_DEC_JCC  = 3'd2,
        KIND_ADD_LEA  = 3'd3,
        KIND_MOV_CMP  = 3'd4,
        KIND_NONE     = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_WAIT,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic        action;
        logic [63:0] first_address;
        logic [7:0]  first_opcode;
        logic [63:0] second_address;
        logic [7:0]  second_opcode;
        logic [7:0]  second_extra;
        logic [3:0]  second_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  fusion_kind;
        logic        entry_stored;
        logic [63:0] target_address;
        logic [7:0]  compare_opcode;
        logic [31:0] run_count;
        logic [9:0]  entries_used;
        logic [63:0] attempt_total;
        logic [63:0] success_total;
    } out_item_t;

    // Classified work passed from front to back.
    typedef struct packed {
        logic        lookup;
        logic [2:0]  kind;
        logic [63:0] address;
        logic [63:0] target;
        logic [7:0]  opcode;
    } task_t;

    function automatic logic is_cmp_like(input logic [7:0] op);
        return (op >= 8'h38 && op <= 8'h3D) || (op >= 8'h80 && op <= 8'h83);
    endfunction

    function automatic logic [2:0] classify(input logic [7:0] op1,
                                            input logic [7:0] op2,
                                            input logic [7:0] ex2);
        logic jcc;
        jcc = (op2 >= 8'h70 && op2 <= 8'h7F) ||
              (op2 == 8'h0F && ex2 >= 8'h80 && ex2 <= 8'h8F);
        if (jcc && is_cmp_like(op1)) return KIND_CMP_JCC;
        if (jcc && (op1 == 8'h84 || op1 == 8'h85 || op1 == 8'hA8 || op1 == 8'hA9 ||
                    op1 == 8'hF6 || op1 == 8'hF7)) return KIND_TEST_JCC;
        if (jcc && (op1 == 8'hFE || op1 == 8'hFF)) return KIND_DEC_JCC;
        if (op1 == 8'h8D && (op2 <= 8'h05 || (op2 >= 8'h80 && op2 <= 8'h83)))
            return KIND_ADD_LEA;
        if (((op1 >= 8'h88 && op1 <= 8'h8B) || op1 == 8'hC6 || op1 == 8'hC7) &&
            is_cmp_like(op2)) return KIND_MOV_CMP;
        return KIND_NONE;
    endfunction

endpackage
`default_nettype wire

>>> hdl/moft_front.sv
//------------------------------------------------------------------------------
// moft_front
// Accepts items, classifies the pair and computes the target, then queues
// the classified work in a two-entry FIFO for the back end.
//------------------------------------------------------------------------------
`default_nettype none
module moft_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire moft_pkg::in_item_t s_item,
    output logic                    q_valid,
    input  wire logic               q_ready,
    output moft_pkg::task_t         q_task
);
    import moft_pkg::*;

    task_t        fifo_reg [2];
    logic         wptr_reg, wptr_next;
    logic         rptr_reg, rptr_next;
    logic [1:0]   cnt_reg, cnt_next;
    task_t        t_in;
    logic         push, pop;

    // Classify the incoming pair
    always_comb begin
        t_in.lookup  = s_item.action;
        t_in.kind    = classify(s_item.first_opcode, s_item.second_opcode,
                                s_item.second_extra);
        t_in.address = s_item.first_address;
        t_in.target  = s_item.second_address + {60'd0, s_item.second_length};
        t_in.opcode  = s_item.first_opcode;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_task  = fifo_reg[rptr_reg];

    always_comb begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    // Queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wptr_reg] <= t_in;
        end
    end
endmodule
`default_nettype wire

>>> hdl/moft_back.sv
//------------------------------------------------------------------------------
// moft_back
// Executes queued work against the entry memory: appends fused pairs and
// scans entries in order for lookups, one read per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module moft_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire moft_pkg::task_t     q_task,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output moft_pkg::out_item_t      m_item
);
    import moft_pkg::*;

    localparam int ENT_W = 64 + 64 + 8;

    // Entry memory: address, target, opcode; run counts in their own memory
    logic [ENT_W-1:0] ent_mem [TABLE_DEPTH];
    logic [31:0]      run_mem [TABLE_DEPTH];
    logic [ENT_W-1:0] ent_rd_reg;
    logic [31:0]      run_rd_reg;

    back_state_t      state_reg, state_next;
    task_t            task_reg, task_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] scan_reg, scan_next;   // address issued to memory
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [63:0]      att_reg, att_next;
    logic [63:0]      suc_reg, suc_next;
    out_item_t        out_reg, out_next;
    logic             ov_reg, ov_next;

    logic             ent_we, run_we;
    logic [IDX_W-1:0] wr_idx, rd_idx, run_idx;
    logic [ENT_W-1:0] ent_wdata;
    logic [31:0]      run_wdata;
    logic             rd_pending_reg, rd_pending_next;
    logic [IDX_W-1:0] rd_idx_reg;

    assign m_valid = ov_reg;
    assign m_item  = out_reg;

    // Memories: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (ent_we) ent_mem[wr_idx] <= ent_wdata;
        ent_rd_reg <= ent_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (run_we) run_mem[run_idx] <= run_wdata;
        run_rd_reg <= run_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            fill_reg       <= '0;
            att_reg        <= '0;
            suc_reg        <= '0;
            ov_reg         <= 1'b0;
            rd_pending_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            att_reg        <= att_next;
            suc_reg        <= suc_next;
            ov_reg         <= ov_next;
            rd_pending_reg <= rd_pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        task_reg    <= task_next;
        scan_reg    <= scan_next;
        hit_idx_reg <= hit_idx_next;
        out_reg     <= out_next;
    end

    // Sequencer
    always_comb begin
        logic        fused;
        logic        room;
        logic [63:0] r_addr;
        state_next      = state_reg;
        task_next       = task_reg;
        fill_next       = fill_reg;
        scan_next       = scan_reg;
        hit_idx_next    = hit_idx_reg;
        att_next        = att_reg;
        suc_next        = suc_reg;
        out_next        = out_reg;
        ov_next         = ov_reg && !m_ready;
        rd_pending_next = 1'b0;
        q_ready         = 1'b0;
        ent_we          = 1'b0;
        run_we          = 1'b0;
        wr_idx          = fill_reg[IDX_W-1:0];
        ent_wdata       = {task_reg.address, task_reg.target, task_reg.opcode};
        run_wdata       = 32'd0;
        run_idx         = fill_reg[IDX_W-1:0];
        rd_idx          = scan_reg[IDX_W-1:0];
        fused           = (task_reg.kind != KIND_NONE);
        room            = (fill_reg < FILL_W'(TABLE_DEPTH));
        r_addr          = ent_rd_reg[ENT_W-1 -: 64];

        case (state_reg)
            BK_IDLE: begin
                q_ready = !ov_reg || m_ready;
                if (q_valid && q_ready) begin
                    task_next = q_task;
                    scan_next = '0;
                    state_next = q_task.lookup ? BK_SCAN : BK_DONE;
                    rd_idx = '0;
                    rd_pending_next = q_task.lookup;
                end
            end
            BK_SCAN: begin
                // Compare the entry read last cycle; issue the next read
                if (rd_pending_reg && scan_reg < fill_reg &&
                    r_addr == task_reg.address) begin
                    hit_idx_next = rd_idx_reg;
                    state_next   = BK_WAIT;
                end else if (rd_pending_reg &&
                             FILL_W'(scan_reg + 1'b1) < fill_reg) begin
                    scan_next       = scan_reg + 1'b1;
                    rd_idx          = scan_next[IDX_W-1:0];
                    rd_pending_next = 1'b1;
                end else begin
                    state_next = BK_DONE;
                end
            end
            BK_WAIT: begin
                // Hit: report and bump the run count
                if (!ov_reg || m_ready) begin
                    run_we  = 1'b1;
                    run_idx = hit_idx_reg;
                    run_wdata = run_rd_reg + 32'd1;
                    out_next.status         = ST_HIT;
                    out_next.fusion_kind    = KIND_NONE;
                    out_next.entry_stored   = 1'b0;
                    out_next.target_address = ent_rd_reg[ENT_W-65 -: 64];
                    out_next.compare_opcode = ent_rd_reg[7:0];
                    out_next.run_count      = run_rd_reg;
                    out_next.entries_used   = USED_W'(fill_reg);
                    out_next.attempt_total  = att_reg;
                    out_next.success_total  = suc_reg;
                    ov_next    = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            BK_DONE: begin
                if (!ov_reg || m_ready) begin
                    out_next.fusion_kind    = KIND_NONE;
                    out_next.entry_stored   = 1'b0;
                    out_next.target_address = '0;
                    out_next.compare_opcode = '0;
                    out_next.run_count      = '0;
                    if (task_reg.lookup) begin
                        out_next.status = ST_MISS;
                    end else begin
                        att_next = att_reg + 64'd1;
                        out_next.fusion_kind = task_reg.kind;
                        if (fused) begin
                            suc_next = suc_reg + 64'd1;
                            out_next.status         = ST_FUSED;
                            out_next.target_address = task_reg.target;
                            out_next.compare_opcode = task_reg.opcode;
                            if (room) begin
                                ent_we    = 1'b1;
                                run_we    = 1'b1;
                                fill_next = fill_reg + 1'b1;
                                out_next.entry_stored = 1'b1;
                            end
                        end else begin
                            out_next.status = ST_NO_FUSE;
                        end
                    end
                    out_next.entries_used  = USED_W'(fill_next);
                    out_next.attempt_total = att_next;
                    out_next.success_total = suc_next;
                    ov_next    = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> hdl/macro_op_fusion_table.sv
// A try-fuse item goes through the back end in order: it is taken from the
// queue, then the table is updated and the result register loaded. A lookup
// that hits entry k scans entries 0 to k first; a miss scans every stored
// entry, or none if the table is empty. The scan is set by the single read
// port of the entry memory, so it reads up to TABLE_DEPTH entries in order.
// A stalled result holds the back end until m_ready rises.
// A two-item queue lets the input side keep accepting while the back end scans.
//------------------------------------------------------------------------------
// macro_op_fusion_table
// Macro-op fusion pair detector with a fused-entry table and lookup.
//------------------------------------------------------------------------------
`default_nettype none
module macro_op_fusion_table (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire moft_pkg::in_item_t   s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output moft_pkg::out_item_t       m_item
);
    import moft_pkg::*;

    logic  q_valid, q_ready;
    task_t q_task;

    // Front: accept and classify
    moft_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_task(q_task)
    );

    // Back: table update and lookup
    moft_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_task(q_task),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );
endmodule
`default_nettype wire

>>> hdl/moft_checker.sv
//------------------------------------------------------------------------------
// moft_checker
// Port-level checks on the fusion table results.
//------------------------------------------------------------------------------
`default_nettype none
`include "macro_op_fusion_table_macros.svh"
module moft_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire moft_pkg::out_item_t m_item
);
    import moft_pkg::*;

    // Stalled result holds
    `MOFT_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item), "result changed while stalled")
    // Lookup results never store
    `MOFT_ASSERT_IMP(a_lk_nostore, aclk, aresetn, m_valid && (m_item.status == ST_HIT || m_item.status == ST_MISS), !m_item.entry_stored && m_item.fusion_kind == KIND_NONE, "lookup stored an entry")
    // Not fusable carries kind none and zero target
    `MOFT_ASSERT_IMP(a_nofuse, aclk, aresetn, m_valid && m_item.status == ST_NO_FUSE, m_item.fusion_kind == KIND_NONE && m_item.target_address == 64'd0, "bad not-fusable result")
    // Successes never exceed attempts
    `MOFT_ASSERT_IMP(a_count, aclk, aresetn, m_valid, m_item.success_total <= m_item.attempt_total, "success count above attempts")
endmodule

bind macro_op_fusion_table moft_checker u_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
);
`default_nettype wire
